/* rtl/atfp_pkg.sv */
`default_nettype none
package atfp_pkg;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_WAKE = 2'd1,
    TAG_CMD  = 2'd2,
    TAG_DONE = 2'd3
  } tag_t;

  localparam logic [1:0] EV_WAKE = 2'd0;
  localparam logic [1:0] EV_CMD  = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;

  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [11:0] VALUE_MAX = 12'd255;
  localparam logic [1:0] DIGITS_MAX = 2'd3;

  typedef struct packed {
    logic [3:0] char_position;
    tag_t       tag_kind;
    logic       frame_invalid;
    logic [7:0] number_value;
    logic [1:0] digit_count;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] value;
  } event_t;

  function automatic logic [7:0] wake_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h77;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h6b;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h63;
      2'd1:    c = 8'h6d;
      2'd2:    c = 8'h64;
      default: c = CH_COLON;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] done_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h64;
      2'd1:    c = 8'h6f;
      2'd2:    c = 8'h6e;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/atfp_byte_step.sv */
`default_nettype none
module atfp_byte_step (
  input  atfp_pkg::state_t st,
  input  logic [7:0]       rx_byte,
  input  logic             frame_end,
  output atfp_pkg::state_t st_next,
  output atfp_pkg::event_t ev
);

  logic [3:0]  pos;
  logic [3:0]  tlen;
  logic [7:0]  want;
  logic        is_digit;
  logic [11:0] acc;

  assign pos      = st.char_position;
  assign tlen     = (st.tag_kind == atfp_pkg::TAG_CMD) ? 4'd3 : 4'd4;
  assign want     = (st.tag_kind == atfp_pkg::TAG_CMD) ? atfp_pkg::cmd_char(pos[1:0])
                                                       : atfp_pkg::done_char(pos[1:0]);
  assign is_digit = (rx_byte >= atfp_pkg::CH_ZERO) && (rx_byte <= atfp_pkg::CH_NINE);
  // value * 10 + digit, low nibble of an ascii digit is its value
  assign acc = ({4'd0, st.number_value} << 3) + ({4'd0, st.number_value} << 1)
             + {8'd0, rx_byte[3:0]};

  always_comb begin
    st_next  = st;
    ev.valid = 1'b0;
    ev.kind  = atfp_pkg::EV_WAKE;
    ev.value = 8'd0;

    if (!st.frame_invalid) begin
      if (pos == 4'd0) begin
        unique case (rx_byte)
          atfp_pkg::wake_char(2'd0): st_next.tag_kind = atfp_pkg::TAG_WAKE;
          atfp_pkg::cmd_char(2'd0):  st_next.tag_kind = atfp_pkg::TAG_CMD;
          atfp_pkg::done_char(2'd0): st_next.tag_kind = atfp_pkg::TAG_DONE;
          default:                   st_next.frame_invalid = 1'b1;
        endcase
      end else if (st.tag_kind == atfp_pkg::TAG_WAKE) begin
        if (pos >= 4'd4 || rx_byte != atfp_pkg::wake_char(pos[1:0]))
          st_next.frame_invalid = 1'b1;
      end else if (st.tag_kind == atfp_pkg::TAG_CMD || st.tag_kind == atfp_pkg::TAG_DONE) begin
        if (pos < tlen) begin
          if (rx_byte != want) st_next.frame_invalid = 1'b1;
        end else if (pos == tlen) begin
          if (rx_byte != atfp_pkg::CH_COLON) st_next.frame_invalid = 1'b1;
        end else if (!is_digit || st.digit_count >= atfp_pkg::DIGITS_MAX
                     || acc > atfp_pkg::VALUE_MAX) begin
          st_next.frame_invalid = 1'b1;
        end else begin
          st_next.number_value = acc[7:0];
          st_next.digit_count  = st.digit_count + 2'd1;
        end
      end else begin
        st_next.frame_invalid = 1'b1;
      end
    end

    if (pos != atfp_pkg::POS_MAX) st_next.char_position = pos + 4'd1;

    if (frame_end) begin
      if (!st_next.frame_invalid) begin
        if (st_next.tag_kind == atfp_pkg::TAG_WAKE && st_next.char_position == 4'd4) begin
          ev.valid = 1'b1;
        end else if ((st_next.tag_kind == atfp_pkg::TAG_CMD
                      || st_next.tag_kind == atfp_pkg::TAG_DONE)
                     && st_next.digit_count != 2'd0) begin
          ev.valid = 1'b1;
          ev.kind  = (st_next.tag_kind == atfp_pkg::TAG_CMD) ? atfp_pkg::EV_CMD
                                                             : atfp_pkg::EV_DONE;
          ev.value = st_next.number_value;
        end
      end
      st_next = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/ascii_tag_frame_parser_top.sv */
// a frame's event is registered in the output register from the input register that holds its last byte
// throughput: one byte per cycle, limited only by the output register being taken
// a held byte waits in the input register while the output register is stalled
// reset (rst, synchronous): clears the frame state and empties both registers
`default_nettype none
module ascii_tag_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] event_value
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_end;
  logic             adv;
  atfp_pkg::state_t st;
  atfp_pkg::state_t st_next;
  atfp_pkg::event_t ev;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  atfp_byte_step u_step (
    .st        (st),
    .rx_byte   (s1_byte),
    .frame_end (s1_end),
    .st_next   (st_next),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) out_valid <= s1_valid && ev.valid;
      if (adv && s1_valid) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
      s1_end  <= frame_end;
    end
    if (adv && s1_valid && ev.valid) begin
      event_kind  <= ev.kind;
      event_value <= ev.value;
    end
  end

  a_mid_frame_silent: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && !s1_end |=> !out_valid)
    else $error("event produced on a byte that does not end a frame");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && s1_end |=> st.char_position == 4'd0 && !st.frame_invalid)
    else $error("frame state not cleared after frame end");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid)
    else $error("input stalled with empty input register");

  a_wake_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == atfp_pkg::EV_WAKE |-> event_value == 8'd0)
    else $error("wake event with nonzero value");

endmodule
`default_nettype wire

/* bench/tb_ascii_tag_frame_parser_top.sv */
`default_nettype none
module tb_ascii_tag_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } parsed_event_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] event_kind;
  logic [7:0] event_value;

  ascii_tag_frame_parser_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_value(event_value)
  );

  // shadow copy of the parser's frame state
  logic [3:0]     seen_count;
  atfp_pkg::tag_t frame_tag;
  logic           frame_dead;
  logic [7:0]     frame_number;
  logic [1:0]     frame_digits;
  parsed_event_t  pending_events[$];

  logic [7:0] frame_bytes[$];
  bit         idle_on;
  int         mismatches;
  int         bytes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_frame_state();
    seen_count   = '0;
    frame_tag    = atfp_pkg::TAG_NONE;
    frame_dead   = 1'b0;
    frame_number = '0;
    frame_digits = '0;
  endfunction

  function automatic void parse_frame_byte(logic [7:0] b, logic last);
    string         word;
    int            tag_len;
    int            acc;
    parsed_event_t ev;
    if (frame_tag == atfp_pkg::TAG_WAKE) begin
      word = "wake";
      tag_len = 4;
    end else if (frame_tag == atfp_pkg::TAG_CMD) begin
      word = "cmd";
      tag_len = 3;
    end else begin
      word = "done";
      tag_len = 4;
    end
    if (!frame_dead) begin
      if (seen_count == 0) begin
        case (b)
          "w":     frame_tag = atfp_pkg::TAG_WAKE;
          "c":     frame_tag = atfp_pkg::TAG_CMD;
          "d":     frame_tag = atfp_pkg::TAG_DONE;
          default: frame_dead = 1'b1;
        endcase
      end else if (frame_tag == atfp_pkg::TAG_WAKE) begin
        if (seen_count >= 4 || b != word[seen_count]) frame_dead = 1'b1;
      end else if (frame_tag == atfp_pkg::TAG_CMD || frame_tag == atfp_pkg::TAG_DONE) begin
        if (seen_count < tag_len) begin
          if (b != word[seen_count]) frame_dead = 1'b1;
        end else if (seen_count == tag_len) begin
          if (b != atfp_pkg::CH_COLON) frame_dead = 1'b1;
        end else if (b < atfp_pkg::CH_ZERO || b > atfp_pkg::CH_NINE
                     || frame_digits == atfp_pkg::DIGITS_MAX) begin
          frame_dead = 1'b1;
        end else begin
          acc = int'(frame_number) * 10 + int'(b - atfp_pkg::CH_ZERO);
          if (acc > int'(atfp_pkg::VALUE_MAX)) begin
            frame_dead = 1'b1;
          end else begin
            frame_number = acc[7:0];
            frame_digits = frame_digits + 2'd1;
          end
        end
      end else begin
        frame_dead = 1'b1;
      end
    end
    if (seen_count != atfp_pkg::POS_MAX) seen_count = seen_count + 4'd1;
    if (last) begin
      if (!frame_dead) begin
        if (frame_tag == atfp_pkg::TAG_WAKE && seen_count == 4'd4) begin
          ev.kind = atfp_pkg::EV_WAKE;
          ev.value = '0;
          pending_events.push_back(ev);
        end else if ((frame_tag == atfp_pkg::TAG_CMD || frame_tag == atfp_pkg::TAG_DONE)
                     && frame_digits != 0) begin
          ev.kind = (frame_tag == atfp_pkg::TAG_CMD) ? atfp_pkg::EV_CMD : atfp_pkg::EV_DONE;
          ev.value = frame_number;
          pending_events.push_back(ev);
        end
      end
      clear_frame_state();
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_request(logic [7:0] b, logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    do @(posedge clk); while (!in_ready);
    parse_frame_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_request(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic void build_good_frame();
    int    n;
    int    v;
    string digits;
    case ($urandom_range(0, 4))
      0: append_text("wake");
      1, 2: append_text("cmd:");
      default: append_text("done:");
    endcase
    if (frame_bytes[0] != "w") begin
      n = $urandom_range(1, 3);
      v = (n == 1) ? $urandom_range(0, 9) : (n == 2) ? $urandom_range(0, 99) :
          ($urandom_range(0, 3) == 0) ? $urandom_range(250, 255) : $urandom_range(0, 255);
      digits = $sformatf("%03d", v);
      append_text(digits.substr(3 - n, 2));
    end
  endfunction

  task automatic test_directed_frames();
    append_text("wake");
    send_frame();
    append_text("cmd:255");
    send_frame();
    append_text("done:0");
    send_frame();
    // unknown first byte, all ones and all zeros
    frame_bytes.push_back(8'hff);
    send_frame();
    frame_bytes.push_back(8'h00);
    send_frame();
    append_text("done:");
    send_frame();
    append_text("wakee");
    send_frame();
  endtask

  task automatic test_random_frames(int count);
    int stop_at;
    int k;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 24) == 0) idle_on = 1'b0;
      else if (!idle_on && $urandom_range(0, 3) == 0) idle_on = 1'b1;
      build_good_frame();
      case ($urandom_range(0, 9))
        5: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        6: begin
          // extra digits may push past three digits or past 255
          k = $urandom_range(1, 3);
          repeat (k) frame_bytes.push_back(atfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        7: begin
          k = $urandom_range(1, frame_bytes.size() - 1);
          repeat (k) void'(frame_bytes.pop_back());
        end
        8: begin
          k = $urandom_range(16, 20);
          while (frame_bytes.size() < k) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        9: begin
          frame_bytes.delete();
          k = $urandom_range(1, 8);
          repeat (k) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_frame();
    end
  endtask

  // result side, stalls drawn per result
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_events
    parsed_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d value %0d", event_kind, event_value);
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || event_value !== want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                     want.kind, want.value, event_kind, event_value);
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    frame_end = 1'b0;
    idle_on   = 1'b1;
    mismatches = 0;
    bytes_sent = 0;
    clear_frame_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_frames();
    test_random_frames(950);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
